// File: rtl/wps_pkg.sv
package wps_pkg;

  localparam int MaxRects    = 64;
  localparam int IdxW        = $clog2(MaxRects);
  localparam int CntW        = IdxW + 1;
  localparam int SmartStep   = 8;
  localparam int OverlapStep = 16;
  localparam int CascadeStep = 30;
  localparam int DefaultSize = 200;
  localparam int ScoreW      = 36;
  localparam logic [ScoreW-1:0] ScoreMax = {ScoreW{1'b1}};

  // wide signed coordinates: enough for area + width sums and step overruns
  localparam int CW = 20;

  typedef enum logic [1:0] {
    REQ_CLEAR = 2'd0,
    REQ_ADD   = 2'd1,
    REQ_PLACE = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    POL_ROW_SMART = 3'd0,
    POL_COL_SMART = 3'd1,
    POL_CASCADE   = 3'd2,
    POL_MOUSE     = 3'd3,
    POL_ROW_MINOV = 3'd4,
    POL_COL_MINOV = 3'd5
  } policy_t;

  typedef enum logic [2:0] {
    CFG_AREA_X    = 3'd0,
    CFG_AREA_Y    = 3'd1,
    CFG_AREA_W    = 3'd2,
    CFG_AREA_H    = 3'd3,
    CFG_POLICY    = 3'd4,
    CFG_RTL       = 3'd5,
    CFG_BTT       = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [14:0]        w;
    logic [14:0]        h;
  } box_t;

  function automatic logic signed [15:0] sat16(input logic signed [CW-1:0] v);
    if (v < -32768) return 16'sh8000;
    if (v > 32767) return 16'sh7fff;
    return v[15:0];
  endfunction

endpackage

// File: rtl/window_placement_search.sv
// Window placement search. Clear gives no result; add raises its result
// from the output state that follows the transfer. Place under cascade or
// under-mouse passes through a start state and then the output state. The
// scan policies read the rectangle table one entry per cycle through its
// single read port, checking every stored rectangle at each grid position
// tried; the first free position ends a scan early. One item is worked on
// at a time; stall is raised while it is in progress.
module window_placement_search (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           req_type,
  input  logic signed [15:0]   rect_x,
  input  logic signed [15:0]   rect_y,
  input  logic [14:0]          rect_w,
  input  logic [14:0]          rect_h,
  input  logic signed [15:0]   cursor_x,
  input  logic signed [15:0]   cursor_y,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [15:0]   place_x,
  output logic signed [15:0]   place_y,
  output logic                 gap_found,
  output logic [35:0]          best_overlap,
  output logic                 table_full,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [15:0]          cfg_data
);
  import wps_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_START, S_READ, S_ACC, S_NEXT, S_OUT
  } state_t;

  state_t state;

  logic signed [15:0] area_x, area_y;
  logic [14:0]        area_width, area_height;
  logic [2:0]         policy;
  logic               right_to_left, bottom_to_top;

  box_t               rect_mem [MaxRects];
  box_t               rd_box;
  logic [CntW-1:0]    rect_count;
  logic [CntW-1:0]    rd_idx;
  logic signed [15:0] cas_x, cas_y;

  // request
  logic signed [CW-1:0] win_w, win_h, cur_x, cur_y;
  logic                 col_major, minov;
  // scan position
  logic signed [CW-1:0] u, v, ud, vd, ulo, uhi, vlo, vhi, vs;
  logic                 hit;
  logic [ScoreW-1:0]    score, best;
  logic                 have;
  logic signed [CW-1:0] bx, by;
  // overlap product stage
  logic [15:0]          ov_dx, ov_dy;
  logic                 ov_valid;
  logic                 rd_valid;

  // result
  logic signed [CW-1:0] res_x, res_y;
  logic                 res_gap, res_full;
  logic [ScoreW-1:0]    res_score;

  assign in_stall = rst || (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      area_x <= '0; area_y <= '0;
      area_width <= 15'd1920; area_height <= 15'd1080;
      policy <= '0; right_to_left <= 1'b0; bottom_to_top <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_AREA_X: area_x <= cfg_data;
        CFG_AREA_Y: area_y <= cfg_data;
        CFG_AREA_W: area_width <= cfg_data[14:0];
        CFG_AREA_H: area_height <= cfg_data[14:0];
        CFG_POLICY: policy <= cfg_data[2:0];
        CFG_RTL:    right_to_left <= cfg_data[0];
        CFG_BTT:    bottom_to_top <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // current window corner from scan axes
  logic signed [CW-1:0] cx, cy, ax, ay, aw, ah;
  assign cx = col_major ? u : v;
  assign cy = col_major ? v : u;
  assign ax = CW'(area_x);
  assign ay = CW'(area_y);
  assign aw = CW'($signed({1'b0, area_width}));
  assign ah = CW'($signed({1'b0, area_height}));

  // compare against stored rectangle
  logic signed [CW-1:0] rx0, ry0, rx1, ry1, ix1, iy1, ix2, iy2;
  logic                 hit_now, ov_pos;
  always_comb begin
    rx0 = CW'(rd_box.x);
    ry0 = CW'(rd_box.y);
    rx1 = rx0 + CW'($signed({1'b0, rd_box.w}));
    ry1 = ry0 + CW'($signed({1'b0, rd_box.h}));
    hit_now = (cx < rx1) && (cx + win_w > rx0) && (cy < ry1) && (cy + win_h > ry0);
    ix1 = (cx > rx0) ? cx : rx0;
    iy1 = (cy > ry0) ? cy : ry0;
    ix2 = ((cx + win_w) < rx1) ? (cx + win_w) : rx1;
    iy2 = ((cy + win_h) < ry1) ? (cy + win_h) : ry1;
    ov_pos = (ix2 > ix1) && (iy2 > iy1);
  end

  logic [ScoreW:0] sum_ext;
  assign sum_ext = {1'b0, score} + (ScoreW+1)'(ov_dx * ov_dy);

  // cascade / mouse helpers
  logic                 cas_bad;
  logic signed [CW-1:0] mx, my;
  always_comb begin
    cas_bad = (CW'(cas_x) < ax) || (CW'(cas_y) < ay) ||
              (CW'(cas_x) + win_w > ax + aw) || (CW'(cas_y) + win_h > ay + ah);
    mx = cur_x - (win_w >>> 1);
    my = cur_y - (win_h >>> 1);
    if (mx < ax) mx = ax;
    if (my < ay) my = ay;
    if (mx + win_w > ax + aw) mx = ax + aw - win_w;
    if (my + win_h > ay + ah) my = ay + ah - win_h;
  end

  always_ff @(posedge clk) begin
    if (state == S_READ) rd_box <= rect_mem[rd_idx[IdxW-1:0]];
    if (state == S_IDLE && in_valid && req_type == REQ_ADD && !rect_count[IdxW])
      rect_mem[rect_count[IdxW-1:0]] <= '{rect_x, rect_y, rect_w, rect_h};
  end

  logic signed [CW-1:0] xhi, yhi, step;
  always_comb begin
    xhi = ax + aw - win_w;
    yhi = ay + ah - win_h;
    step = minov ? CW'(OverlapStep) : CW'(SmartStep);
  end

  logic signed [CW-1:0] v_new, u_new;
  assign v_new = v + vd;
  assign u_new = u + ud;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      rect_count <= '0;
      cas_x <= '0;
      cas_y <= '0;
      rd_valid <= 1'b0;
      ov_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_OUT) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_valid) begin
          win_w <= CW'($signed({1'b0, (rect_w == '0) ? 15'(DefaultSize) : rect_w}));
          win_h <= CW'($signed({1'b0, (rect_h == '0) ? 15'(DefaultSize) : rect_h}));
          cur_x <= CW'(cursor_x);
          cur_y <= CW'(cursor_y);
          col_major <= (policy == POL_COL_SMART) || (policy == POL_COL_MINOV);
          minov <= (policy == POL_ROW_MINOV) || (policy == POL_COL_MINOV);
          res_x <= '0; res_y <= '0; res_gap <= 1'b0; res_score <= '0; res_full <= 1'b0;
          unique case (req_type)
            REQ_CLEAR: rect_count <= '0;
            REQ_ADD: begin
              if (rect_count[IdxW]) res_full <= 1'b1;
              else rect_count <= rect_count + 1'b1;
              state <= S_OUT;
            end
            REQ_PLACE: state <= S_START;
            default: ;
          endcase
        end
        S_START: begin
          state <= S_OUT;
          unique case (policy)
            POL_CASCADE: begin
              if (cas_bad) begin
                // restart point wraps at 16 bits like the stored position
                res_x <= CW'(16'(ax + CW'(CascadeStep)));
                res_y <= CW'(16'(ay + CW'(CascadeStep)));
                cas_x <= 16'(ax + CW'(2*CascadeStep));
                cas_y <= 16'(ay + CW'(2*CascadeStep));
              end else begin
                res_x <= CW'(cas_x);
                res_y <= CW'(cas_y);
                cas_x <= cas_x + 16'(CascadeStep);
                cas_y <= cas_y + 16'(CascadeStep);
              end
            end
            POL_MOUSE: begin
              res_x <= mx;
              res_y <= my;
            end
            POL_ROW_SMART, POL_COL_SMART, POL_ROW_MINOV, POL_COL_MINOV: begin
              ud <= col_major ? (right_to_left ? -step : step)
                              : (bottom_to_top ? -step : step);
              vd <= col_major ? (bottom_to_top ? -step : step)
                              : (right_to_left ? -step : step);
              ulo <= col_major ? ax : ay;
              uhi <= col_major ? xhi : yhi;
              vlo <= col_major ? ay : ax;
              vhi <= col_major ? yhi : xhi;
              u <= col_major ? (right_to_left ? xhi : ax) : (bottom_to_top ? yhi : ay);
              vs <= col_major ? (bottom_to_top ? yhi : ay) : (right_to_left ? xhi : ax);
              v <= col_major ? (bottom_to_top ? yhi : ay) : (right_to_left ? xhi : ax);
              have <= 1'b0; best <= '0; bx <= ax; by <= ay;
              // empty grid falls straight through to the fallback
              if ((col_major ? xhi < ax : yhi < ay) || (col_major ? yhi < ay : xhi < ax)) begin
                res_x <= minov ? ax : ax + CW'(CascadeStep);
                res_y <= minov ? ay : ay + CW'(CascadeStep);
              end else begin
                state <= S_READ;
                rd_idx <= '0; hit <= 1'b0; score <= '0;
                rd_valid <= 1'b0; ov_valid <= 1'b0;
              end
            end
            default: ;
          endcase
        end
        S_READ: begin
          // one entry read per cycle; compare and multiply trail it
          rd_valid <= (rd_idx < rect_count);
          if (rd_idx < rect_count) rd_idx <= rd_idx + 1'b1;
          if (rd_valid) begin
            if (hit_now) hit <= 1'b1;
            ov_dx <= ov_pos ? 16'(ix2 - ix1) : '0;
            ov_dy <= ov_pos ? 16'(iy2 - iy1) : '0;
          end
          ov_valid <= rd_valid;
          if (ov_valid) score <= sum_ext[ScoreW] ? ScoreMax : sum_ext[ScoreW-1:0];
          if (!rd_valid && !ov_valid && rd_idx >= rect_count) state <= S_ACC;
        end
        S_ACC: begin
          state <= S_NEXT;
          if (!minov ? !hit : (score == '0)) begin
            res_x <= cx; res_y <= cy; res_gap <= 1'b1;
            state <= S_OUT;
          end else if (minov && (!have || score < best)) begin
            have <= 1'b1; best <= score; bx <= cx; by <= cy;
          end
        end
        S_NEXT: begin
          rd_idx <= '0; hit <= 1'b0; score <= '0;
          state <= S_READ;
          if (v_new >= vlo && v_new <= vhi) v <= v_new;
          else if (u_new >= ulo && u_new <= uhi) begin
            u <= u_new; v <= vs;
          end else begin
            state <= S_OUT;
            res_x <= minov ? bx : ax + CW'(CascadeStep);
            res_y <= minov ? by : ay + CW'(CascadeStep);
            res_score <= minov ? best : '0;
          end
        end
        S_OUT: if (!out_valid || !out_stall) begin
          out_valid <= 1'b1;
          place_x <= sat16(res_x);
          place_y <= sat16(res_y);
          gap_found <= res_gap;
          best_overlap <= res_score;
          table_full <= res_full;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
